// ===== sv/dpc_pkg.sv =====
package dpc_pkg;

	localparam int MAX_DIM   = 256;
	localparam int COORD_W   = $clog2(MAX_DIM);
	localparam int COORD_MAX = MAX_DIM - 1;
	localparam int STEP_W    = $clog2(COORD_W + 1);

	localparam int PIX_W  = 8;
	localparam int DIM_W  = 9;
	localparam int CNT_W  = 17;
	localparam int SUM_W  = 24;
	localparam int OUT_W  = 9;
	localparam int CFG_IW = 3;
	localparam int CFG_DW = 17;
	localparam int QDEPTH = 2;

	typedef enum logic [CFG_IW-1:0] {
		REG_IMAGE_WIDTH    = 3'd0,
		REG_DARK_THRESHOLD = 3'd1,
		REG_WIN_X_START    = 3'd2,
		REG_WIN_X_END      = 3'd3,
		REG_WIN_Y_START    = 3'd4,
		REG_WIN_Y_END      = 3'd5,
		REG_MIN_COUNT      = 3'd6,
		REG_MAX_COUNT      = 3'd7
	} cfg_idx_t;

	typedef struct packed {
		logic [DIM_W-1:0] image_width;
		logic [PIX_W-1:0] dark_threshold;
		logic [DIM_W-1:0] win_x_start;
		logic [DIM_W-1:0] win_x_end;
		logic [DIM_W-1:0] win_y_start;
		logic [DIM_W-1:0] win_y_end;
		logic [CNT_W-1:0] min_count;
		logic [CNT_W-1:0] max_count;
	} cfg_t;

	typedef struct packed {
		logic [CNT_W-1:0] count;
		logic [SUM_W-1:0] sum_x;
		logic [SUM_W-1:0] sum_y;
	} frame_acc_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

	typedef struct packed {
		logic               busy;
		logic [COORD_W-1:0] quotient;
	} div_status_t;

	typedef enum logic [1:0] {
		B_IDLE,
		B_RUN,
		B_DONE
	} back_state_t;

endpackage

// ===== sv/dpc_front.sv =====
module dpc_front import dpc_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  cfg_t             cfg,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [PIX_W-1:0] s_tdata,   // pixel
	input  logic             s_tlast,   // end_of_frame
	input  q_status_t        qstat,
	output logic             push,
	output frame_acc_t       push_data
);

	logic [COORD_W-1:0] col_q, row_q;
	logic [CNT_W-1:0]   cnt_q, cnt_nx;
	logic [SUM_W-1:0]   sx_q, sy_q, sx_nx, sy_nx;
	logic [DIM_W-1:0]   w_eff, col_inc;
	logic [SUM_W:0]     sx_add, sy_add;
	logic               in_win, accept, row_end;

	assign s_tready = !qstat.full;
	assign accept   = s_tvalid && s_tready;

	always_comb begin
		if (cfg.image_width == '0) begin
			w_eff = DIM_W'(1);
		end else if (cfg.image_width > DIM_W'(MAX_DIM)) begin
			w_eff = DIM_W'(MAX_DIM);
		end else begin
			w_eff = cfg.image_width;
		end
	end

	assign col_inc = DIM_W'(col_q) + DIM_W'(1);
	assign row_end = col_inc >= w_eff;

	assign in_win = (DIM_W'(col_q) >= cfg.win_x_start) && (DIM_W'(col_q) < cfg.win_x_end) &&
		(DIM_W'(row_q) >= cfg.win_y_start) && (DIM_W'(row_q) < cfg.win_y_end) &&
		(s_tdata < cfg.dark_threshold);

	assign sx_add = {1'b0, sx_q} + (SUM_W+1)'(col_q);
	assign sy_add = {1'b0, sy_q} + (SUM_W+1)'(row_q);

	always_comb begin
		cnt_nx = cnt_q;
		sx_nx  = sx_q;
		sy_nx  = sy_q;
		if (in_win) begin
			// saturate all accumulators
			if (cnt_q != '1) cnt_nx = cnt_q + CNT_W'(1);
			sx_nx = sx_add[SUM_W] ? '1 : sx_add[SUM_W-1:0];
			sy_nx = sy_add[SUM_W] ? '1 : sy_add[SUM_W-1:0];
		end
	end

	assign push            = accept && s_tlast;
	assign push_data.count = cnt_nx;
	assign push_data.sum_x = sx_nx;
	assign push_data.sum_y = sy_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			cnt_q <= '0;
			sx_q  <= '0;
			sy_q  <= '0;
		end else if (accept) begin
			if (s_tlast) begin
				col_q <= '0;
				row_q <= '0;
				cnt_q <= '0;
				sx_q  <= '0;
				sy_q  <= '0;
			end else begin
				cnt_q <= cnt_nx;
				sx_q  <= sx_nx;
				sy_q  <= sy_nx;
				if (row_end) begin
					col_q <= '0;
					if (row_q != COORD_W'(COORD_MAX)) row_q <= row_q + COORD_W'(1);
				end else begin
					col_q <= col_inc[COORD_W-1:0];
				end
			end
		end
	end

endmodule

// ===== sv/dpc_queue.sv =====
module dpc_queue import dpc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  frame_acc_t push_data,
	input  logic       pop,
	output frame_acc_t pop_data,
	output q_status_t  qstat
);

	localparam int PTR_W = $clog2(QDEPTH);

	frame_acc_t         mem_q [QDEPTH];
	logic [PTR_W-1:0]   wr_q, rd_q;
	logic [PTR_W:0]     fill_q;

	assign qstat.full  = fill_q == (PTR_W+1)'(QDEPTH);
	assign qstat.empty = fill_q == '0;
	assign pop_data    = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q   <= '0;
			rd_q   <= '0;
			fill_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + PTR_W'(1);
			if (pop)  rd_q <= rd_q + PTR_W'(1);
			if (push && !pop)      fill_q <= fill_q + (PTR_W+1)'(1);
			else if (pop && !push) fill_q <= fill_q - (PTR_W+1)'(1);
		end
	end

endmodule

// ===== sv/dpc_div.sv =====
module dpc_div import dpc_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [SUM_W-1:0] dividend,
	input  logic [CNT_W-1:0] divisor,
	output div_status_t      status
);

	logic [CNT_W-1:0]   rem_q, div_q;
	logic [COORD_W-1:0] bits_q, quo_q;
	logic [STEP_W-1:0]  steps_q;
	logic               sat_q;
	logic [CNT_W:0]     trial;
	logic               fits;

	// one quotient bit per cycle; the upper dividend bits preload the remainder
	assign trial = {rem_q, bits_q[COORD_W-1]};
	assign fits  = trial >= {1'b0, div_q};

	assign status.busy     = steps_q != '0;
	assign status.quotient = sat_q ? '1 : quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			steps_q <= '0;
		end else if (start) begin
			steps_q <= STEP_W'(COORD_W);
		end else if (steps_q != '0) begin
			steps_q <= steps_q - STEP_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			sat_q  <= (SUM_W+1)'(dividend) >= {divisor, {COORD_W{1'b0}}};
			rem_q  <= CNT_W'(dividend[SUM_W-1:COORD_W]);
			bits_q <= dividend[COORD_W-1:0];
			div_q  <= divisor;
			quo_q  <= '0;
		end else if (steps_q != '0) begin
			bits_q <= {bits_q[COORD_W-2:0], 1'b0};
			if (fits) begin
				rem_q <= CNT_W'(trial - {1'b0, div_q});
				quo_q <= {quo_q[COORD_W-2:0], 1'b1};
			end else begin
				rem_q <= trial[CNT_W-1:0];
				quo_q <= {quo_q[COORD_W-2:0], 1'b0};
			end
		end
	end

endmodule

// ===== sv/dpc_back.sv =====
module dpc_back import dpc_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  cfg_t                       cfg,
	input  q_status_t                  qstat,
	input  frame_acc_t                 pop_data,
	output logic                       pop,
	output logic                       m_tvalid,
	input  logic                       m_tready,
	output logic [2*OUT_W+CNT_W+4:0]   m_tdata,   // centre_x, centre_y, dark_total, zero pad
	output logic                       m_tuser    // found
);

	back_state_t      state_q, state_nx;
	div_status_t      dx, dy;
	logic [CNT_W-1:0] cnt_q;
	logic             found_q, found_nx, out_free, load;
	logic             m_tvalid_q;
	logic [2*OUT_W+CNT_W+4:0] tdata_q;
	logic             tuser_q;

	assign found_nx = (pop_data.count != '0) && (pop_data.count >= cfg.min_count) &&
		(pop_data.count <= cfg.max_count);
	assign out_free = !m_tvalid_q || m_tready;

	dpc_div u_div_x (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (pop && found_nx),
		.dividend (pop_data.sum_x),
		.divisor  (pop_data.count),
		.status   (dx)
	);

	dpc_div u_div_y (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (pop && found_nx),
		.dividend (pop_data.sum_y),
		.divisor  (pop_data.count),
		.status   (dy)
	);

	always_comb begin
		state_nx = state_q;
		case (state_q)
			B_IDLE: begin
				if (!qstat.empty) state_nx = found_nx ? B_RUN : B_DONE;
			end
			B_RUN: begin
				if (!dx.busy && !dy.busy) state_nx = B_DONE;
			end
			B_DONE: begin
				if (out_free) state_nx = B_IDLE;
			end
			default: state_nx = B_IDLE;
		endcase
	end

	always_comb begin
		pop  = 1'b0;
		load = 1'b0;
		case (state_q)
			B_IDLE:  pop  = !qstat.empty;
			B_DONE:  load = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= B_IDLE;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (load)          m_tvalid_q <= 1'b1;
			else if (m_tready) m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cnt_q   <= pop_data.count;
			found_q <= found_nx;
		end
		if (load) begin
			tuser_q <= found_q;
			if (found_q) begin
				tdata_q <= {5'b0, cnt_q, (OUT_W)'(dy.quotient), (OUT_W)'(dx.quotient)};
			end else begin
				tdata_q <= {5'b0, {CNT_W{1'b0}}, {OUT_W{1'b1}}, {OUT_W{1'b1}}};
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = tdata_q;
	assign m_tuser  = tuser_q;

endmodule

// ===== sv/dark_pixel_centroid.sv =====
// Pixels are accepted one per cycle; s_tready drops only while two finished frames wait.
// Frame totals wait in a two-entry queue; the back end takes one frame at a time, runs one
// shift-subtract divider per coordinate only when the frame is found, then registers the result
// once the output is free; a stalled output delays it.
// Reset (arst_n low, asynchronous) restores register defaults and clears all counters.
module dark_pixel_centroid import dpc_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [CFG_IW-1:0]         cfg_index,
	input  logic [CFG_DW-1:0]         cfg_data,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	input  logic [PIX_W-1:0]          s_tdata,   // pixel
	input  logic                      s_tlast,   // end_of_frame
	output logic                      m_tvalid,
	input  logic                      m_tready,
	output logic [2*OUT_W+CNT_W+4:0]  m_tdata,   // centre_x, centre_y, dark_total, zero pad
	output logic                      m_tuser    // found
);

	cfg_t       cfg_q;
	q_status_t  qstat;
	frame_acc_t push_data, pop_data;
	logic       push, pop;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.image_width    <= DIM_W'(96);
			cfg_q.dark_threshold <= PIX_W'(85);
			cfg_q.win_x_start    <= DIM_W'(10);
			cfg_q.win_x_end      <= DIM_W'(86);
			cfg_q.win_y_start    <= DIM_W'(10);
			cfg_q.win_y_end      <= DIM_W'(86);
			cfg_q.min_count      <= CNT_W'(180);
			cfg_q.max_count      <= CNT_W'(3176);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_idx_t'(cfg_index))
				REG_IMAGE_WIDTH:    cfg_q.image_width    <= cfg_data[DIM_W-1:0];
				REG_DARK_THRESHOLD: cfg_q.dark_threshold <= cfg_data[PIX_W-1:0];
				REG_WIN_X_START:    cfg_q.win_x_start    <= cfg_data[DIM_W-1:0];
				REG_WIN_X_END:      cfg_q.win_x_end      <= cfg_data[DIM_W-1:0];
				REG_WIN_Y_START:    cfg_q.win_y_start    <= cfg_data[DIM_W-1:0];
				REG_WIN_Y_END:      cfg_q.win_y_end      <= cfg_data[DIM_W-1:0];
				REG_MIN_COUNT:      cfg_q.min_count      <= cfg_data[CNT_W-1:0];
				REG_MAX_COUNT:      cfg_q.max_count      <= cfg_data[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	dpc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.qstat     (qstat),
		.push      (push),
		.push_data (push_data)
	);

	dpc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (pop_data),
		.qstat     (qstat)
	);

	dpc_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.qstat    (qstat),
		.pop_data (pop_data),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

endmodule

// ===== sv/dpc_checker.sv =====
module dpc_checker import dpc_pkg::*; (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      cfg_valid,
	input logic                      cfg_ready,
	input logic                      m_tvalid,
	input logic                      m_tready,
	input logic [2*OUT_W+CNT_W+4:0]  m_tdata,
	input logic                      m_tuser
);

	// a waiting result holds
	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// a not-found result carries -1 coordinates and a zero count
	a_not_found: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |->
		m_tdata[2*OUT_W+CNT_W-1:0] == {{CNT_W{1'b0}}, {2*OUT_W{1'b1}}})
		else $error("not-found result has wrong fields");

	// a found result has a nonzero count and coordinates in range
	a_found: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |->
		m_tdata[2*OUT_W+CNT_W-1:2*OUT_W] != '0 && !m_tdata[OUT_W-1] && !m_tdata[2*OUT_W-1])
		else $error("found result out of range");

	// the configuration channel never stalls
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("configuration write stalled");

endmodule

bind dark_pixel_centroid dpc_checker u_checker (.*);

// ===== bench/dpc_result_checker.sv =====
`timescale 1ns / 1ps

module dpc_result_checker import dpc_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_valid,
	input  logic                     cfg_ready,
	input  logic [CFG_IW-1:0]        cfg_index,
	input  logic [CFG_DW-1:0]        cfg_data,
	input  logic                     s_tvalid,
	input  logic                     s_tready,
	input  logic [PIX_W-1:0]         s_tdata,   // pixel
	input  logic                     s_tlast,   // end_of_frame
	input  logic                     m_tvalid,
	input  logic                     m_tready,
	input  logic [2*OUT_W+CNT_W+4:0] m_tdata,   // centre_x, centre_y, dark_total, zero pad
	input  logic                     m_tuser,   // found
	output int                       errors,
	output int                       pending,
	output int                       frames,
	output int                       found_frames,
	output int                       pixels
);

	localparam int unsigned SUM_LIM = (1 << SUM_W) - 1;
	localparam int unsigned CNT_LIM = (1 << CNT_W) - 1;

	typedef struct packed {
		logic             found;
		logic [OUT_W-1:0] centre_x;
		logic [OUT_W-1:0] centre_y;
		logic [CNT_W-1:0] dark_total;
	} centroid_t;

	centroid_t          centroid_q[$];
	centroid_t          exp_res;
	cfg_t               regs;
	logic [COORD_W-1:0] col;
	logic [COORD_W-1:0] row;
	logic [SUM_W-1:0]   sum_x;
	logic [SUM_W-1:0]   sum_y;
	logic [CNT_W-1:0]   dark_cnt;

	task automatic clear_frame();
		col      = '0;
		row      = '0;
		sum_x    = '0;
		sum_y    = '0;
		dark_cnt = '0;
	endtask

	task automatic accumulate(input logic [PIX_W-1:0] pix, input logic last);
		int unsigned w;
		int unsigned x;
		int unsigned y;
		int unsigned tmp;
		int unsigned qx;
		int unsigned qy;
		centroid_t   res;

		w = regs.image_width;
		if (w == 0)
			w = 1;
		if (w > MAX_DIM)
			w = MAX_DIM;
		x = col;
		y = row;

		if (x >= regs.win_x_start && x < regs.win_x_end &&
		    y >= regs.win_y_start && y < regs.win_y_end &&
		    pix < regs.dark_threshold) begin
			tmp = dark_cnt + 1;
			dark_cnt = CNT_W'((tmp > CNT_LIM) ? CNT_LIM : tmp);
			tmp = sum_x + x;
			sum_x = SUM_W'((tmp > SUM_LIM) ? SUM_LIM : tmp);
			tmp = sum_y + y;
			sum_y = SUM_W'((tmp > SUM_LIM) ? SUM_LIM : tmp);
		end

		// wrap the column at the row end, hold the row at its last value
		if (x + 1 >= w) begin
			col = '0;
			if (row < COORD_MAX)
				row = row + 1'b1;
		end else begin
			col = COORD_W'(x + 1);
		end

		if (last) begin
			if (dark_cnt != 0 && dark_cnt >= regs.min_count && dark_cnt <= regs.max_count) begin
				qx = sum_x / dark_cnt;
				qy = sum_y / dark_cnt;
				if (qx > COORD_MAX)
					qx = COORD_MAX;
				if (qy > COORD_MAX)
					qy = COORD_MAX;
				res.found      = 1'b1;
				res.centre_x   = OUT_W'(qx);
				res.centre_y   = OUT_W'(qy);
				res.dark_total = dark_cnt;
			end else begin
				res.found      = 1'b0;
				res.centre_x   = '1;
				res.centre_y   = '1;
				res.dark_total = '0;
			end
			centroid_q.push_back(res);
			clear_frame();
		end
	endtask

	task automatic report_field(input string name, input int exp_v, input int act_v);
		$display("%0t ns: result %0d, %s mismatch: expected %0d, actual %0d",
		         $time, frames, name, exp_v, act_v);
		errors++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs.image_width    = 9'd96;
			regs.dark_threshold = 8'd85;
			regs.win_x_start    = 9'd10;
			regs.win_x_end      = 9'd86;
			regs.win_y_start    = 9'd10;
			regs.win_y_end      = 9'd86;
			regs.min_count      = 17'd180;
			regs.max_count      = 17'd3176;
			clear_frame();
			centroid_q.delete();
			errors       = 0;
			pending      = 0;
			frames       = 0;
			found_frames = 0;
			pixels       = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_idx_t'(cfg_index))
					REG_IMAGE_WIDTH:    regs.image_width    = cfg_data[DIM_W-1:0];
					REG_DARK_THRESHOLD: regs.dark_threshold = cfg_data[PIX_W-1:0];
					REG_WIN_X_START:    regs.win_x_start    = cfg_data[DIM_W-1:0];
					REG_WIN_X_END:      regs.win_x_end      = cfg_data[DIM_W-1:0];
					REG_WIN_Y_START:    regs.win_y_start    = cfg_data[DIM_W-1:0];
					REG_WIN_Y_END:      regs.win_y_end      = cfg_data[DIM_W-1:0];
					REG_MIN_COUNT:      regs.min_count      = cfg_data[CNT_W-1:0];
					REG_MAX_COUNT:      regs.max_count      = cfg_data[CNT_W-1:0];
					default: ;
				endcase
			end

			if (s_tvalid && s_tready) begin
				pixels++;
				accumulate(s_tdata, s_tlast);
			end

			if (m_tvalid && m_tready) begin
				if (centroid_q.size() == 0) begin
					$display("%0t ns: result with no frame pending: expected none, actual tdata %h tuser %b",
					         $time, m_tdata, m_tuser);
					errors++;
				end else begin
					exp_res = centroid_q.pop_front();
					if (m_tuser !== exp_res.found)
						report_field("found", exp_res.found, m_tuser);
					if (m_tdata[OUT_W-1:0] !== exp_res.centre_x)
						report_field("centre_x", $signed(exp_res.centre_x),
						             $signed(m_tdata[OUT_W-1:0]));
					if (m_tdata[2*OUT_W-1:OUT_W] !== exp_res.centre_y)
						report_field("centre_y", $signed(exp_res.centre_y),
						             $signed(m_tdata[2*OUT_W-1:OUT_W]));
					if (m_tdata[2*OUT_W+CNT_W-1:2*OUT_W] !== exp_res.dark_total)
						report_field("dark_total", exp_res.dark_total,
						             m_tdata[2*OUT_W+CNT_W-1:2*OUT_W]);
					frames++;
					if (exp_res.found)
						found_frames++;
				end
			end

			pending = centroid_q.size();
		end
	end

endmodule

// ===== bench/tb_dark_pixel_centroid.sv =====
`timescale 1ns / 1ps

module tb_dark_pixel_centroid;
	import dpc_pkg::*;

	localparam int STALL_LIMIT        = 4000;
	localparam int SETTLE_CYCLES      = 16;
	localparam int SEGMENTS_PER_MIX   = 5;
	localparam int PIXELS_PER_SEGMENT = 55;
	localparam int SAT_FRAME_LEN      = 300;

	logic                     clk       = 1'b0;
	logic                     arst_n    = 1'b0;
	logic                     cfg_valid = 1'b0;
	logic [CFG_IW-1:0]        cfg_index = '0;
	logic [CFG_DW-1:0]        cfg_data  = '0;
	logic                     s_tvalid  = 1'b0;
	logic [PIX_W-1:0]         s_tdata   = '0;
	logic                     s_tlast   = 1'b0;
	logic                     m_tready  = 1'b0;
	logic                     cfg_ready;
	logic                     s_tready;
	logic                     m_tvalid;
	logic [2*OUT_W+CNT_W+4:0] m_tdata;
	logic                     m_tuser;

	int src_idle_pct  = 0;
	int snk_stall_pct = 0;
	int idle_cycles   = 0;
	int settings_used = 0;
	int errors;
	int pending;
	int frames;
	int found_frames;
	int pixels;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	dark_pixel_centroid uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	dpc_result_checker result_chk (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.s_tvalid     (s_tvalid),
		.s_tready     (s_tready),
		.s_tdata      (s_tdata),
		.s_tlast      (s_tlast),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.m_tdata      (m_tdata),
		.m_tuser      (m_tuser),
		.errors       (errors),
		.pending      (pending),
		.frames       (frames),
		.found_frames (found_frames),
		.pixels       (pixels)
	);

	always @(negedge clk) begin
		m_tready <= ($urandom_range(99) >= snk_stall_pct);
	end

	// end the run when no transaction of any kind happens for too long
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
		    (cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles + 1 >= STALL_LIMIT) begin
			$display("%0t ns: no transaction for %0d cycles, %0d results outstanding",
			         $time, STALL_LIMIT, pending);
			$display("Verification failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	task automatic send_pixel(input logic [PIX_W-1:0] pix, input logic last);
		while ($urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= pix;
		s_tlast  <= last;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DW-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	// wait for every frame result, then let the back end go quiet
	task automatic wait_settled();
		while (pending != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic apply_config(input cfg_t c);
		s_tvalid <= 1'b0;
		wait_settled();
		write_reg(REG_IMAGE_WIDTH, c.image_width);
		write_reg(REG_DARK_THRESHOLD, c.dark_threshold);
		write_reg(REG_WIN_X_START, c.win_x_start);
		write_reg(REG_WIN_X_END, c.win_x_end);
		write_reg(REG_WIN_Y_START, c.win_y_start);
		write_reg(REG_WIN_Y_END, c.win_y_end);
		write_reg(REG_MIN_COUNT, c.min_count);
		write_reg(REG_MAX_COUNT, c.max_count);
		cfg_valid <= 1'b0;
		settings_used++;
	endtask

	// half uniform, half at or below the threshold to get dark pixels
	function automatic logic [PIX_W-1:0] pick_pixel(input logic [PIX_W-1:0] thr);
		if ($urandom_range(1))
			return PIX_W'($urandom_range(255));
		return PIX_W'($urandom_range(thr));
	endfunction

	function automatic cfg_t random_config();
		cfg_t        c;
		logic [95:0] raw;
		int          w;
		int          lo;

		case ($urandom_range(9))
			0: c = '0;
			1: begin
				c.image_width    = 9'd256;
				c.dark_threshold = 8'd255;
				c.win_x_start    = 9'd256;
				c.win_x_end      = 9'd256;
				c.win_y_start    = 9'd256;
				c.win_y_end      = 9'd256;
				c.min_count      = 17'd65536;
				c.max_count      = 17'd65536;
			end
			2: begin
				raw = {$urandom, $urandom, $urandom};
				c = raw[$bits(cfg_t)-1:0];
			end
			default: begin
				// small frames with a window that mostly fits them
				w = $urandom_range(1, 12);
				c.image_width    = DIM_W'(w);
				c.dark_threshold = PIX_W'($urandom_range(255));
				lo = $urandom_range(0, w - 1);
				c.win_x_start    = DIM_W'(lo);
				c.win_x_end      = DIM_W'($urandom_range(lo, w + 1));
				lo = $urandom_range(0, 3);
				c.win_y_start    = DIM_W'(lo);
				c.win_y_end      = DIM_W'($urandom_range(lo, 8));
				lo = $urandom_range(0, 4);
				c.min_count      = CNT_W'(lo);
				c.max_count      = CNT_W'($urandom_range(lo, 30));
			end
		endcase
		return c;
	endfunction

	initial begin
		cfg_t c;
		int   mix;
		int   seg;
		int   seg_pixels;
		int   len;
		int   i;

		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		c.image_width    = 9'd4;
		c.dark_threshold = 8'd128;
		c.win_x_start    = 9'd1;
		c.win_x_end      = 9'd3;
		c.win_y_start    = 9'd0;
		c.win_y_end      = 9'd2;
		c.min_count      = 17'd0;
		c.max_count      = 17'd3;
		apply_config(c);
		// nothing dark in the window: not found even with a zero minimum
		send_pixel(8'd0, 1'b1);
		// two dark pixels, threshold edge and pixel extremes
		send_pixel(8'd255, 1'b0);
		send_pixel(8'd0, 1'b0);
		send_pixel(8'd127, 1'b0);
		send_pixel(8'd128, 1'b0);
		send_pixel(8'd0, 1'b0);
		send_pixel(8'd255, 1'b1);
		// four dark pixels, above the maximum
		for (i = 0; i < 8; i++)
			send_pixel(8'd0, i == 7);

		// zero width acts as one column per row
		c.image_width    = 9'd0;
		c.dark_threshold = 8'd1;
		c.win_x_start    = 9'd0;
		c.win_x_end      = 9'd256;
		c.win_y_start    = 9'd0;
		c.win_y_end      = 9'd256;
		c.min_count      = 17'd3;
		c.max_count      = 17'd3;
		apply_config(c);
		for (i = 0; i < 3; i++)
			send_pixel(8'd0, i == 2);
		send_pixel(8'd0, 1'b0);
		send_pixel(8'd1, 1'b1);

		// empty column range and inverted row range
		c.image_width    = 9'd4;
		c.dark_threshold = 8'd255;
		c.win_x_start    = 9'd3;
		c.win_x_end      = 9'd3;
		c.win_y_start    = 9'd2;
		c.win_y_end      = 9'd0;
		c.min_count      = 17'd0;
		c.max_count      = 17'd65536;
		apply_config(c);
		send_pixel(8'd0, 1'b0);
		send_pixel(8'd0, 1'b1);

		// one column per row and more rows than the row counter holds
		c.image_width    = 9'd1;
		c.dark_threshold = 8'd255;
		c.win_x_start    = 9'd0;
		c.win_x_end      = 9'd256;
		c.win_y_start    = 9'd0;
		c.win_y_end      = 9'd256;
		c.min_count      = 17'd1;
		c.max_count      = 17'd65536;
		apply_config(c);
		for (i = 0; i < SAT_FRAME_LEN; i++)
			send_pixel(PIX_W'($urandom_range(254)), i == SAT_FRAME_LEN - 1);

		for (mix = 0; mix < 4; mix++) begin
			case (mix)
				0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
				1: begin src_idle_pct = 86; snk_stall_pct = 0;  end
				2: begin src_idle_pct = 0;  snk_stall_pct = 86; end
				default: begin src_idle_pct = 23; snk_stall_pct = 23; end
			endcase
			for (seg = 0; seg < SEGMENTS_PER_MIX; seg++) begin
				c = random_config();
				apply_config(c);
				seg_pixels = 0;
				while (seg_pixels < PIXELS_PER_SEGMENT) begin
					// mostly short frames, now and then one with many rows
					len = ($urandom_range(19) == 0) ? $urandom_range(41, 300)
					                                : $urandom_range(1, 40);
					for (i = 0; i < len; i++)
						send_pixel(pick_pixel(c.dark_threshold), i == len - 1);
					seg_pixels += len;
				end
			end
		end

		s_tvalid <= 1'b0;
		wait_settled();

		$display("Run covered %0d pixels and %0d frame results, %0d of them with a centroid,",
		         pixels, frames, found_frames);
		$display("over %0d register settings and four source idle / sink stall mixes.",
		         settings_used);
		if (errors == 0 && pending == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
